// ===== hw/rtl/sequenced_frame_sample_ring_assert.svh =====
// Assertion macros used by the checker of this block.
`ifndef SEQUENCED_FRAME_SAMPLE_RING_ASSERT_SVH
`define SEQUENCED_FRAME_SAMPLE_RING_ASSERT_SVH

// Same-cycle implication, skipped while reset is low.
`define SFSR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfsr check failed");

// Next-cycle implication, skipped while reset is low.
`define SFSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfsr check failed");

`endif

// ===== hw/rtl/sfsr_pkg.sv =====
package sfsr_pkg;

    localparam int SPF_W     = 8;
    localparam int SLOT_W    = 6;
    localparam int FRAME_LEN = 1 << SPF_W;
    localparam int SLOT_CNT  = 1 << SLOT_W;
    localparam int RING_W    = SPF_W + SLOT_W;
    localparam int RING_CAP  = 1 << RING_W;
    localparam int IDX_W     = 40;
    localparam int HEAD_W    = 41;
    localparam int BUF_W     = RING_W + 1;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [31:0]      frame_seq;
        logic [7:0]       sample_offset;
        logic [31:0]      sample_bits;
        logic [IDX_W-1:0] query_index;
    } t_req;

    typedef struct packed {
        logic [31:0]       read_bits;
        logic              present;
        logic              accepted;
        logic [HEAD_W-1:0] head_position;
        logic [31:0]       dropped_count;
        logic [BUF_W-1:0]  buffered_count;
    } t_rsp;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic rd_en;
        logic exec;
        logic pack;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
    } t_sts;

endpackage

// ===== hw/rtl/sfsr_ram.sv =====
module sfsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/sfsr_ctrl.sv =====
module sfsr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output sfsr_pkg::t_cmd o_cmd,
    input  sfsr_pkg::t_sts i_sts
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC,
        S_PACK,
        S_SEND
    } t_state;

    t_state r_state;
    logic   r_in_stall;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_in_stall  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (i_sts.clr_done) begin
                        r_state    <= S_IDLE;
                        r_in_stall <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state    <= S_READ;
                        r_in_stall <= 1'b1;
                    end
                end
                S_READ: r_state <= S_EXEC;
                S_EXEC: r_state <= S_PACK;
                S_PACK: begin
                    r_state     <= S_SEND;
                    r_out_valid <= 1'b1;
                end
                S_SEND: begin
                    if (!i_out_stall) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b0;
                        r_in_stall  <= 1'b0;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.clr_step = (r_state == S_CLEAR);
        o_cmd.capture  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.rd_en    = (r_state == S_READ);
        o_cmd.exec     = (r_state == S_EXEC);
        o_cmd.pack     = (r_state == S_PACK);
    end

    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/sfsr_dp.sv =====
module sfsr_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sfsr_pkg::t_req i_req,
    output sfsr_pkg::t_rsp o_rsp,
    input  sfsr_pkg::t_cmd i_cmd,
    output sfsr_pkg::t_sts o_sts
);

    sfsr_pkg::t_req r_req;
    sfsr_pkg::t_rsp r_rsp;

    logic [sfsr_pkg::RING_W-1:0]      r_clr_addr;
    logic [sfsr_pkg::SLOT_CNT-1:0]    r_slot_valid;
    logic [sfsr_pkg::HEAD_W-1:0]      r_head;
    logic [sfsr_pkg::IDX_W-1:0]       r_first;
    logic                             r_have;
    logic [32:0]                      r_next_exp;
    logic [31:0]                      r_drop;
    logic                             r_taken;
    logic [31:0]                      r_rd;
    logic                             r_pres;
    logic                             r_acc;

    logic [31:0]                      store_rdata;
    logic [31:0]                      tag_rdata;
    logic                             store_we;
    logic [sfsr_pkg::RING_W-1:0]      store_waddr;
    logic [31:0]                      store_wdata;

    logic [31:0]                      seq;
    logic [sfsr_pkg::SLOT_W-1:0]      slot;
    logic [sfsr_pkg::IDX_W-1:0]       base;
    logic [sfsr_pkg::IDX_W-1:0]       abs_idx;
    logic                             is_write;
    logic                             off_ok;
    logic                             is_start;
    logic                             stale;
    logic                             start_ok;
    logic                             taken_now;
    logic                             write_ok;
    logic [32:0]                      seq_ext;
    logic [32:0]                      gap;
    logic [32:0]                      drop_sum;
    logic [31:0]                      n_drop;
    logic [sfsr_pkg::HEAD_W-1:0]      abs_p1;
    logic [sfsr_pkg::HEAD_W-1:0]      n_head;
    logic [sfsr_pkg::HEAD_W-1:0]      span;
    logic [sfsr_pkg::BUF_W-1:0]       n_buf;
    logic [sfsr_pkg::IDX_W-sfsr_pkg::SPF_W-1:0] q_frame;
    logic [sfsr_pkg::SLOT_W-1:0]      q_slot;

    assign seq      = r_req.frame_seq;
    assign slot     = seq[sfsr_pkg::SLOT_W-1:0];
    assign base     = {seq, {sfsr_pkg::SPF_W{1'b0}}};
    assign abs_idx  = {seq, r_req.sample_offset[sfsr_pkg::SPF_W-1:0]};
    assign is_write = (r_req.kind == sfsr_pkg::KIND_WRITE);
    assign off_ok   = (r_req.sample_offset >> sfsr_pkg::SPF_W) == '0;
    assign is_start = (r_req.sample_offset == '0);

    // A frame is stale when its last sample lies before the oldest index the ring still holds.
    assign stale = r_have
        && (r_head >= sfsr_pkg::HEAD_W'(sfsr_pkg::RING_CAP))
        && (({1'b0, base} + sfsr_pkg::HEAD_W'(sfsr_pkg::FRAME_LEN))
            <= (r_head - sfsr_pkg::HEAD_W'(sfsr_pkg::RING_CAP)));
    assign start_ok  = !stale;
    assign taken_now = is_start ? start_ok : r_taken;
    assign write_ok  = is_write && off_ok && taken_now;

    assign seq_ext  = {1'b0, seq};
    assign gap      = seq_ext - r_next_exp;
    assign drop_sum = {1'b0, r_drop} + {1'b0, gap[31:0]};
    assign n_drop   = (seq_ext > r_next_exp) ? (drop_sum[32] ? '1 : drop_sum[31:0]) : r_drop;

    assign abs_p1 = {1'b0, abs_idx} + sfsr_pkg::HEAD_W'(1);
    assign n_head = (abs_p1 > r_head) ? abs_p1 : r_head;

    assign q_frame = r_req.query_index[sfsr_pkg::IDX_W-1:sfsr_pkg::SPF_W];
    assign q_slot  = r_req.query_index[sfsr_pkg::RING_W-1:sfsr_pkg::SPF_W];

    assign span = r_head - {1'b0, r_first};
    always_comb begin
        n_buf = '0;
        if (r_have && (r_head > {1'b0, r_first})) begin
            if (span > sfsr_pkg::HEAD_W'(sfsr_pkg::RING_CAP)) begin
                n_buf = sfsr_pkg::BUF_W'(sfsr_pkg::RING_CAP);
            end else begin
                n_buf = span[sfsr_pkg::BUF_W-1:0];
            end
        end
    end

    // Clearing pass writes zeros; afterwards only accepted samples reach the store.
    assign store_we    = i_cmd.clr_step || (i_cmd.exec && write_ok);
    assign store_waddr = i_cmd.clr_step ? r_clr_addr : abs_idx[sfsr_pkg::RING_W-1:0];
    assign store_wdata = i_cmd.clr_step ? 32'd0 : r_req.sample_bits;

    sfsr_ram #(
        .WIDTH (32),
        .DEPTH (sfsr_pkg::RING_CAP)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (store_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_req.query_index[sfsr_pkg::RING_W-1:0]),
        .o_rdata (store_rdata)
    );

    sfsr_ram #(
        .WIDTH (32),
        .DEPTH (sfsr_pkg::SLOT_CNT)
    ) u_tag (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && is_write && off_ok && is_start && start_ok),
        .i_waddr (slot),
        .i_wdata (seq),
        .i_re    (i_cmd.rd_en),
        .i_raddr (q_slot),
        .o_rdata (tag_rdata)
    );

    assign o_sts.clr_done = &r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr   <= '0;
            r_slot_valid <= '0;
            r_head       <= '0;
            r_first      <= '0;
            r_have       <= 1'b0;
            r_next_exp   <= '0;
            r_drop       <= '0;
            r_taken      <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.exec) begin
                unique case (r_req.kind)
                    sfsr_pkg::KIND_WRITE: begin
                        if (off_ok && is_start) begin
                            r_taken <= start_ok;
                            if (start_ok) begin
                                r_drop             <= n_drop;
                                r_next_exp         <= seq_ext + 33'd1;
                                r_slot_valid[slot] <= 1'b1;
                                r_have             <= 1'b1;
                                if (!r_have || (base < r_first)) begin
                                    r_first <= base;
                                end
                            end
                        end
                        if (write_ok) begin
                            r_head <= n_head;
                        end
                    end
                    sfsr_pkg::KIND_CLEAR: begin
                        r_slot_valid <= '0;
                        r_head       <= '0;
                        r_first      <= '0;
                        r_have       <= 1'b0;
                        r_next_exp   <= '0;
                        r_drop       <= '0;
                        r_taken      <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.exec) begin
            r_acc <= write_ok;
            if (r_req.kind == sfsr_pkg::KIND_QUERY) begin
                r_rd   <= store_rdata;
                r_pres <= r_slot_valid[q_slot]
                    && (q_frame == (sfsr_pkg::IDX_W - sfsr_pkg::SPF_W)'(tag_rdata));
            end else begin
                r_rd   <= '0;
                r_pres <= 1'b0;
            end
        end
        if (i_cmd.pack) begin
            r_rsp.read_bits      <= r_rd;
            r_rsp.present        <= r_pres;
            r_rsp.accepted       <= r_acc;
            r_rsp.head_position  <= r_head;
            r_rsp.dropped_count  <= r_drop;
            r_rsp.buffered_count <= n_buf;
        end
    end

    assign o_rsp = r_rsp;

endmodule

// ===== hw/rtl/sequenced_frame_sample_ring.sv =====
// A result becomes valid after its request passes the read, execute and pack states.
// A new request is taken only after the previous result has left; the
// request runs through capture, store/tag read, bookkeeping update and pack.
// Reset (synchronous, active low) clears the bookkeeping, then a clearing pass
// zeroes the 16384-entry sample store, one entry a cycle, with input stall high.
module sequenced_frame_sample_ring (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  sfsr_pkg::t_req i_req,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output sfsr_pkg::t_rsp o_rsp
);

    sfsr_pkg::t_cmd cmd;
    sfsr_pkg::t_sts sts;

    sfsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    sfsr_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule

// ===== hw/rtl/sfsr_checker.sv =====
`include "sequenced_frame_sample_ring_assert.svh"

module sfsr_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input sfsr_pkg::t_rsp o_rsp
);

    logic in_take;
    logic out_wait;
    logic buf_ok;
    assign in_take  = i_in_valid && !o_in_stall;
    assign out_wait = o_out_valid && i_out_stall;
    assign buf_ok   = o_rsp.buffered_count <= sfsr_pkg::BUF_W'(sfsr_pkg::RING_CAP);

    // Hold a stalled result.
    `SFSR_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, out_wait, o_out_valid && $stable(o_rsp))

    // No new request while a result waits.
    `SFSR_ASSERT_NOW(a_one_in_flight, i_clk, i_rst_n, o_out_valid, o_in_stall)

    // An accepted request closes the input and has no result yet.
    `SFSR_ASSERT_NEXT(a_take_closes, i_clk, i_rst_n, in_take, o_in_stall && !o_out_valid)

    // Fill level never exceeds the ring.
    `SFSR_ASSERT_NOW(a_buf_cap, i_clk, i_rst_n, o_out_valid, buf_ok)

    // A result never carries both a write ack and a query hit.
    `SFSR_ASSERT_NOW(a_acc_pres, i_clk, i_rst_n, o_out_valid, !(o_rsp.accepted && o_rsp.present))

endmodule

bind sequenced_frame_sample_ring sfsr_checker u_sfsr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_rsp       (o_rsp)
);
